/* hw/rtl/lcar_pkg.sv */
package lcar_pkg;

	// Conversion word of the serial ADC
	localparam int SAMPLE_BITS = 24;
	// Length of the boxcar average
	localparam int AVG_LEN = 4;
	localparam int SLOT_W = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1;
	localparam int SUM_W = SAMPLE_BITS + $clog2(AVG_LEN);
	localparam int PULSE_W = 5;

	// Calibration datapath widths
	localparam int DIFF_W = 33;
	localparam int MULT_W = 32;
	localparam int PROD_W = DIFF_W + MULT_W;
	localparam int SCALED_W = PROD_W + 1;
	localparam int DIV_W = 31;
	localparam int STEP_W = 7;
	localparam int MUL_STEPS = MULT_W;
	localparam int DIV_STEPS = SCALED_W;

	localparam logic [SAMPLE_BITS-1:0] SIGN_BIT = 24'h800000;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_GAIN_MODE       = 3'd0,
		CFG_CAL_OFFSET      = 3'd1,
		CFG_GAIN_MULTIPLIER = 3'd2,
		CFG_GAIN_DIVISOR    = 3'd3,
		CFG_TARE            = 3'd4
	} cfg_idx_t;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_PREP = 9'b000000010,
		ST_MUL  = 9'b000000100,
		ST_ADD  = 9'b000001000,
		ST_ABS  = 9'b000010000,
		ST_DIV  = 9'b000100000,
		ST_NEGQ = 9'b001000000,
		ST_SUM  = 9'b010000000,
		ST_HOLD = 9'b100000000
	} state_t;

endpackage

/* hw/rtl/load_cell_adc_reader_calibrated_core.sv */
// Load cell ADC reader with moving average and calibration. Each input item is
// one serial-clock slot carrying the sampled data line level; each item yields
// exactly one result with the clock request for that slot, a sample-done flag
// and the calibrated weight ((avg - cal_offset) * gain_multiplier + div/2) / div
// + tare, truncated toward zero and saturated to 32 bits signed. A low data
// line while idle starts a read of 24 bits, MSB first, followed by one, two or
// three gain pulses; the finished sample is biased into 0..0xFFFFFF and enters
// a 4-entry boxcar average. An item whose weight is unchanged moves from idle to
// the hold state, which loads the output register once that is free; the block
// takes no new item until the result is in the output register. The item that
// completes a sample, and the next item after any configuration write, recompute
// the weight through the prep, multiply, add, abs, divide, negate and sum states
// ahead of the hold state: a bit-serial shift-add multiplier (one multiplier bit
// per cycle) and a restoring divider (one quotient bit per cycle) do the work.
// The output register lets the block take the next item while a
// result still waits. Configuration writes are taken only while the block is
// idle, and an offered write holds off the input item for that cycle.
module load_cell_adc_reader_calibrated_core
	import lcar_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input slots
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        data_bit,
	// results
	output logic        out_valid,
	input  logic        out_stall,
	output logic        clock_pulse,
	output logic        sample_done,
	output logic [31:0] weight,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	state_t st_q;

	// configuration registers
	logic [1:0]        gain_mode_q;
	logic [31:0]       cal_offset_q;
	logic [31:0]       gain_mult_q;
	logic [DIV_W-1:0]  gain_div_q;
	logic [31:0]       tare_q;

	// serial read state
	logic                   reading_q;
	logic [PULSE_W-1:0]     pulse_count_q;
	logic [SAMPLE_BITS-1:0] shift_q;

	// moving average
	logic [SAMPLE_BITS-1:0] win_q [AVG_LEN];
	logic [SUM_W-1:0]       avg_sum_q;
	logic [SLOT_W-1:0]      avg_slot_q;
	logic [SAMPLE_BITS-1:0] avg_value_q;

	// calibration datapath
	logic                 dirty_q;
	logic                 neg_q;
	logic [DIFF_W-1:0]    mcand_q;
	logic [PROD_W-1:0]    prod_q;
	logic [SCALED_W-1:0]  scaled_q;
	logic                 sgn_q;
	logic [SCALED_W-1:0]  quo_q;
	logic [DIV_W-1:0]     rem_q;
	logic [SCALED_W:0]    sq_q;
	logic [STEP_W-1:0]    step_q;
	logic [31:0]          weight_q;

	// pending result of the current item
	logic pend_clk_q;
	logic pend_done_q;

	// output register
	logic        out_valid_q;
	logic        out_clk_q;
	logic        out_done_q;
	logic [31:0] out_weight_q;

	logic                   accept;
	logic                   cfg_wr;
	logic [PULSE_W-1:0]     pulse_next;
	logic [PULSE_W-1:0]     pulse_end;
	logic                   done_now;
	logic [SAMPLE_BITS-1:0] biased;
	logic [SUM_W-1:0]       sum_next;
	logic [DIFF_W-1:0]      diff;
	logic [DIFF_W-1:0]      diff_mag;
	logic [MULT_W-1:0]      mult_mag;
	logic [DIFF_W:0]        mul_sum;
	logic [DIV_W-1:0]       div_eff;
	logic [SCALED_W-1:0]    half;
	logic [DIV_W:0]         trial;
	logic                   trial_ge;
	logic [SCALED_W+1:0]    wsum;
	logic [31:0]            wsat;
	logic                   out_load;

	// A pending configuration write goes first; the item is held off while it is offered.
	assign accept = in_valid && (st_q == ST_IDLE) && !cfg_valid;
	assign in_stall = (st_q != ST_IDLE) || cfg_valid;
	assign cfg_ready = (st_q == ST_IDLE);
	assign cfg_wr = cfg_valid && cfg_ready;

	// Gain mode 0 adds one pulse, 1 adds two, 2 and above add three.
	assign pulse_end = PULSE_W'(SAMPLE_BITS) + ((gain_mode_q >= 2'd2) ?
		PULSE_W'(3) : PULSE_W'(gain_mode_q) + PULSE_W'(1));
	assign pulse_next = pulse_count_q + PULSE_W'(1);
	assign done_now = reading_q && (pulse_next >= pulse_end);

	// Sign-extend then add 0x800000 modulo 2^24: the same as flipping the MSB.
	assign biased = shift_q ^ SIGN_BIT;
	assign sum_next = avg_sum_q - SUM_W'(win_q[avg_slot_q]) + SUM_W'(biased);

	// avg - offset, 33-bit two's complement, and the operand magnitudes
	assign diff = {{(DIFF_W-SAMPLE_BITS){1'b0}}, avg_value_q} - {cal_offset_q[31], cal_offset_q};
	assign diff_mag = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
	assign mult_mag = gain_mult_q[31] ? (~gain_mult_q + MULT_W'(1)) : gain_mult_q;

	// Shift-add: add the multiplicand into the high half when the low bit is set.
	assign mul_sum = {1'b0, prod_q[PROD_W-1:MULT_W]} + {1'b0, mcand_q};

	// A zero divisor acts as one.
	assign div_eff = (gain_div_q == '0) ? DIV_W'(1) : gain_div_q;
	assign half = SCALED_W'(div_eff[DIV_W-1:1]);

	// Restoring division: one quotient bit per cycle.
	assign trial = {rem_q, quo_q[SCALED_W-1]};
	assign trial_ge = (trial >= {1'b0, div_eff});

	// Add tare and clamp to the 32-bit signed range.
	assign wsum = {sq_q[SCALED_W], sq_q} + {{(SCALED_W-30){tare_q[31]}}, tare_q};
	always_comb begin
		if (wsum[SCALED_W+1:31] == '0 || wsum[SCALED_W+1:31] == '1) begin
			wsat = wsum[31:0];
		end else if (wsum[SCALED_W+1]) begin
			wsat = 32'h80000000;
		end else begin
			wsat = 32'h7FFFFFFF;
		end
	end

	assign out_load = (st_q == ST_HOLD) && (!out_valid_q || !out_stall);

	// Control, read sequencer, average and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_IDLE;
			gain_mode_q   <= '0;
			cal_offset_q  <= '0;
			gain_mult_q   <= 32'd1;
			gain_div_q    <= DIV_W'(1);
			tare_q        <= '0;
			reading_q     <= 1'b0;
			pulse_count_q <= '0;
			shift_q       <= '0;
			for (int i = 0; i < AVG_LEN; i++) begin
				win_q[i] <= '0;
			end
			avg_sum_q     <= '0;
			avg_slot_q    <= '0;
			avg_value_q   <= '0;
			dirty_q       <= 1'b0;
			weight_q      <= '0;
			step_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				dirty_q <= 1'b1;
				unique case (cfg_index)
					CFG_GAIN_MODE:       gain_mode_q  <= cfg_data[1:0];
					CFG_CAL_OFFSET:      cal_offset_q <= cfg_data;
					CFG_GAIN_MULTIPLIER: gain_mult_q  <= cfg_data;
					CFG_GAIN_DIVISOR:    gain_div_q   <= cfg_data[DIV_W-1:0];
					CFG_TARE:            tare_q       <= cfg_data;
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						if (!reading_q) begin
							// a low line means a conversion is ready; pulse from next slot
							if (!data_bit) begin
								reading_q     <= 1'b1;
								pulse_count_q <= '0;
								shift_q       <= '0;
							end
						end else begin
							if (pulse_count_q < PULSE_W'(SAMPLE_BITS)) begin
								shift_q <= {shift_q[SAMPLE_BITS-2:0], data_bit};
							end
							if (done_now) begin
								reading_q       <= 1'b0;
								pulse_count_q   <= '0;
								win_q[avg_slot_q] <= biased;
								avg_sum_q       <= sum_next;
								avg_value_q     <= SAMPLE_BITS'(sum_next / AVG_LEN);
								avg_slot_q      <= (avg_slot_q == SLOT_W'(AVG_LEN - 1)) ?
									'0 : avg_slot_q + SLOT_W'(1);
							end else begin
								pulse_count_q <= pulse_next;
							end
						end
						// recompute only when the average or the calibration moved
						st_q <= (dirty_q || done_now) ? ST_PREP : ST_HOLD;
					end
				end
				ST_PREP: begin
					step_q <= '0;
					st_q   <= ST_MUL;
				end
				ST_MUL: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(MUL_STEPS - 1)) begin
						st_q <= ST_ADD;
					end
				end
				ST_ADD: st_q <= ST_ABS;
				ST_ABS: begin
					step_q <= '0;
					st_q   <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						st_q <= ST_NEGQ;
					end
				end
				ST_NEGQ: st_q <= ST_SUM;
				ST_SUM: begin
					weight_q <= wsat;
					dirty_q  <= 1'b0;
					st_q     <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			pend_clk_q  <= reading_q;
			pend_done_q <= done_now;
		end
		unique case (st_q)
			ST_PREP: begin
				neg_q   <= diff[DIFF_W-1] ^ gain_mult_q[31];
				mcand_q <= diff_mag;
				prod_q  <= {{DIFF_W{1'b0}}, mult_mag};
			end
			ST_MUL: begin
				prod_q <= prod_q[0] ? {mul_sum, prod_q[MULT_W-1:1]} :
					{1'b0, prod_q[PROD_W-1:1]};
			end
			ST_ADD: begin
				scaled_q <= neg_q ? (half - {1'b0, prod_q}) : ({1'b0, prod_q} + half);
			end
			ST_ABS: begin
				sgn_q <= scaled_q[SCALED_W-1];
				quo_q <= scaled_q[SCALED_W-1] ? (~scaled_q + SCALED_W'(1)) : scaled_q;
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= trial_ge ? DIV_W'(trial - {1'b0, div_eff}) : trial[DIV_W-1:0];
				quo_q <= {quo_q[SCALED_W-2:0], trial_ge};
			end
			ST_NEGQ: begin
				sq_q <= sgn_q ? (~{1'b0, quo_q} + (SCALED_W+1)'(1)) : {1'b0, quo_q};
			end
			default: ;
		endcase
		if (out_load) begin
			out_clk_q    <= pend_clk_q;
			out_done_q   <= pend_done_q;
			out_weight_q <= weight_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign clock_pulse = out_clk_q;
	assign sample_done = out_done_q;
	assign weight      = out_weight_q;

endmodule
